// ===== sv/rtt_pkg.sv =====
`timescale 1ns / 1ps
package rtt_pkg;
   localparam int QueueDepthDefault = 32;
   localparam int BufferSlots = 1024;
   localparam logic [9:0] HandleMask = 10'(BufferSlots - 1);
   localparam int AckWindow = 64;
   localparam int MaxResults = 32;
   localparam logic [5:0] MaxBatchReset = 6'd8;

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_PUSH  = 2'd1,
      KIND_ACK   = 2'd2,
      KIND_SCAN  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      RES_DONE    = 3'd0,
      RES_EMPTY   = 3'd1,
      RES_FULL    = 3'd2,
      RES_DUE     = 3'd3,
      RES_NONEDUE = 3'd4
   } code_type;

   localparam logic [0:0] CSR_BATCH_CAP = 1'd0;

   typedef struct packed {
      logic [31:0] number;
      logic [63:0] first_sent;
      logic [63:0] last_sent;
      logic [31:0] retries;
      logic [15:0] length;
      logic [9:0]  handle;
   } entry_type;

   localparam int EntryWidth = $bits(entry_type);
endpackage

// ===== sv/rtt_ram.sv =====
`timescale 1ns / 1ps
module rtt_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sv/retransmission_tracker.sv =====
`timescale 1ns / 1ps
// Retransmission queue of up to QUEUE_DEPTH sent packets, kept in push order in one
// entry RAM with a registered read. Clear, push and rejected pushes go through the
// finish state to the output. An ack or timeout scan walks the pending entries through
// the RAM read port, with a read state and an evaluate state per entry; an ack compacts
// survivors in place as it walks. A scan reports each due entry, up to the batch limit,
// and holds a report until the next due entry or the end of the walk settles its last
// flag; each report waits for the output to be taken, which stretches the walk while
// results are stalled. One item is worked on at a time.
module retransmission_tracker
   import rtt_pkg::*;
#(
   parameter int QUEUE_DEPTH  = QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_packet_number,
   input  logic [63:0] req_time_ms,
   input  logic [15:0] req_frame_length,
   input  logic [9:0]  req_frame_handle,
   input  logic [31:0] req_ack_largest,
   input  logic [63:0] req_ack_mask,
   input  logic [31:0] req_timeout_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_code,
   output logic [31:0] rsp_due_packet_number,
   output logic [9:0]  rsp_due_handle,
   output logic [15:0] rsp_due_length,
   output logic [31:0] rsp_due_retries,
   output logic [63:0] rsp_due_first_sent_ms,
   output logic [20:0] rsp_bytes_in_flight,
   output logic [5:0]  rsp_pending_count,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int TW = CW + 16;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,
      S_EVAL  = 6'b000100,
      S_EMIT  = 6'b001000,
      S_FIN   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  batch_cap_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [TW-1:0] total_ff, total_in;
   logic [1:0]  kind_ff;
   logic [31:0] largest_ff, timeout_ff;
   logic [63:0] mask_ff, now_ff;
   logic [CW-1:0] rd_ff, rd_in, keep_ff, keep_in;
   logic [5:0]  sent_ff, sent_in, limit_ff;
   logic        hold_ff, hold_in;
   logic        ovalid_ff;
   code_type    ocode_ff, ocode_in;
   entry_type   oent_ff, oent_in;
   logic        load_out;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data;

   rtt_ram #(.Width(EntryWidth), .Depth(QUEUE_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   assign pready = 1'b1;
   assign prdata = {26'd0, batch_cap_ff};
   assign req_stall = (state_ff != S_IDLE);
   assign rd_addr = rd_ff[AW-1:0];

   logic        acked, due, accept;
   logic [31:0] gap;
   logic [63:0] elapsed;
   always_comb begin
      gap = largest_ff - rd_data.number;
      acked = 1'b0;
      if (rd_data.number <= largest_ff) begin
         if (gap == 32'd0 || gap >= 32'(AckWindow)) acked = 1'b1;
         else acked = mask_ff[gap[5:0]];
      end
      elapsed = now_ff - rd_data.last_sent;
      due = (elapsed >= {32'd0, timeout_ff});
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      total_in = total_ff;
      rd_in    = rd_ff;
      keep_in  = keep_ff;
      sent_in  = sent_ff;
      hold_in  = hold_ff;
      ocode_in = ocode_ff;
      oent_in  = oent_ff;
      load_out = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = keep_ff[AW-1:0];
      wr_data  = rd_data;
      unique case (state_ff)
         S_IDLE: begin
            rd_in = '0;
            keep_in = '0;
            sent_in = '0;
            hold_in = 1'b0;
            if (accept) begin
               unique case (kind_type'(req_kind))
                  KIND_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                     ocode_in = RES_DONE;
                     state_in = S_FIN;
                  end
                  KIND_PUSH: begin
                     if (req_frame_length == 16'd0) begin
                        ocode_in = RES_EMPTY;
                     end else if (count_ff >= CW'(QUEUE_DEPTH)) begin
                        ocode_in = RES_FULL;
                     end else begin
                        ocode_in = RES_DONE;
                        wr_en = 1'b1;
                        wr_addr = count_ff[AW-1:0];
                        wr_data.number = req_packet_number;
                        wr_data.first_sent = req_time_ms;
                        wr_data.last_sent = req_time_ms;
                        wr_data.retries = '0;
                        wr_data.length = req_frame_length;
                        wr_data.handle = req_frame_handle & HandleMask;
                        count_in = count_ff + CW'(1);
                        total_in = total_ff + TW'(req_frame_length);
                     end
                     state_in = S_FIN;
                  end
                  KIND_ACK: begin
                     total_in = '0;
                     state_in = S_READ;
                  end
                  default: begin
                     state_in = S_READ;
                  end
               endcase
            end
         end
         S_READ: begin
            if (rd_ff >= count_ff ||
                (kind_ff == KIND_SCAN &&
                 (limit_ff == 6'd0 || timeout_ff == 32'd0))) begin
               ocode_in = (kind_ff == KIND_SCAN) ? RES_NONEDUE : RES_DONE;
               if (kind_ff == KIND_ACK) count_in = keep_ff;
               state_in = hold_ff ? S_EMIT : S_FIN;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (kind_ff == KIND_ACK) begin
               rd_in = rd_ff + CW'(1);
               state_in = S_READ;
               if (!acked) begin
                  wr_en = 1'b1;
                  keep_in = keep_ff + CW'(1);
                  total_in = total_ff + TW'(rd_data.length);
               end
            end else if (!due) begin
               rd_in = rd_ff + CW'(1);
               state_in = S_READ;
            end else if (!hold_ff || !ovalid_ff || !rsp_stall) begin
               load_out = hold_ff;
               wr_en = 1'b1;
               wr_addr = rd_ff[AW-1:0];
               wr_data.last_sent = now_ff;
               wr_data.retries = rd_data.retries + 32'd1;
               rd_in = rd_ff + CW'(1);
               sent_in = sent_ff + 6'd1;
               oent_in = wr_data;
               ocode_in = RES_DUE;
               hold_in = 1'b1;
               state_in = (sent_in == limit_ff) ? S_EMIT : S_READ;
            end
         end
         S_EMIT: begin
            if (!ovalid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            if (!ovalid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         batch_cap_ff <= MaxBatchReset;
         count_ff <= '0;
         total_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
         if (psel && penable && pwrite && pready && paddr[2] == CSR_BATCH_CAP) begin
            batch_cap_ff <= pwdata[5:0];
         end
         if (load_out) ovalid_ff <= 1'b1;
         else if (!rsp_stall) ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      keep_ff <= keep_in;
      sent_ff <= sent_in;
      hold_ff <= hold_in;
      ocode_ff <= ocode_in;
      oent_ff <= oent_in;
      if (accept) begin
         kind_ff <= req_kind;
         largest_ff <= req_ack_largest;
         mask_ff <= req_ack_mask;
         now_ff <= req_time_ms;
         timeout_ff <= req_timeout_ms;
         limit_ff <= (batch_cap_ff > 6'(MaxResults)) ? 6'(MaxResults) : batch_cap_ff;
      end
      if (load_out) begin
         rsp_result_code <= (state_ff == S_FIN) ? ocode_ff : RES_DUE;
         rsp_last <= (state_ff != S_EVAL);
         if (state_ff != S_FIN) begin
            rsp_due_packet_number <= oent_ff.number;
            rsp_due_handle <= oent_ff.handle;
            rsp_due_length <= oent_ff.length;
            rsp_due_retries <= oent_ff.retries;
            rsp_due_first_sent_ms <= oent_ff.first_sent;
         end else begin
            rsp_due_packet_number <= '0;
            rsp_due_handle <= '0;
            rsp_due_length <= '0;
            rsp_due_retries <= '0;
            rsp_due_first_sent_ms <= '0;
         end
         rsp_bytes_in_flight <= 21'(total_in);
         rsp_pending_count <= 6'(count_in);
      end
   end
   assign rsp_valid = ovalid_ff;
endmodule
